// File: design/vptw_pkg.sv
// Shared types, constants and register codes for the vertex projection unit.
`timescale 1ns / 1ps
package vptw_pkg;

	// Fixed-point format of coordinates and matrix words.
	localparam int COORD_W = 32;
	localparam int FB      = 16;
	localparam int PROD_W  = 2 * COORD_W;
	localparam int ACC_W   = PROD_W + 2;

	// Matrix store: model matrix in words 0..15, projection matrix in 16..31.
	localparam int MAT_DEPTH = 32;
	localparam int MAT_AW    = $clog2(MAT_DEPTH);
	localparam int PROJ_BASE = 16;

	// Queue between the transform front and the divide back.
	localparam int FIFO_DEPTH = 8;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
	localparam int FIFO_CW    = FIFO_AW + 1;

	// Configuration port.
	localparam int APB_AW = 4;
	localparam int APB_DW = 32;

	// Request codes.
	localparam logic REQ_LOAD    = 1'b0;
	localparam logic REQ_PROJECT = 1'b1;

	// Register indexes (word address bits).
	localparam logic [1:0] REG_VP_ORIGIN_X = 2'd0;
	localparam logic [1:0] REG_VP_ORIGIN_Y = 2'd1;
	localparam logic [1:0] REG_VP_WIDTH    = 2'd2;
	localparam logic [1:0] REG_VP_HEIGHT   = 2'd3;

	typedef logic signed [COORD_W-1:0] fx_t;

	localparam fx_t FX_MAX = {1'b0, {(COORD_W-1){1'b1}}};
	localparam fx_t FX_MIN = {1'b1, {(COORD_W-1){1'b0}}};
	localparam fx_t ONE_FX = fx_t'(1) <<< FB;

	typedef struct packed {
		logic              req_type;
		logic [4:0]        elem_index;
		logic signed [31:0] elem_value;
		logic signed [31:0] obj_x;
		logic signed [31:0] obj_y;
		logic signed [31:0] obj_z;
	} in_beat_t;

	typedef struct packed {
		logic signed [31:0] win_x;
		logic signed [31:0] win_y;
		logic signed [31:0] win_z;
		logic               ok;
	} out_beat_t;

	// Clip-space point handed from front to back.
	typedef struct packed {
		fx_t x;
		fx_t y;
		fx_t z;
		fx_t w;
	} clip_t;

	// Viewport settings.
	typedef struct packed {
		logic signed [15:0] origin_x;
		logic signed [15:0] origin_y;
		logic [14:0]        width;
		logic [14:0]        height;
	} vp_cfg_t;

endpackage

// File: design/vptw_fifo.sv
// Short queue that carries clip-space points from the front to the back.
`timescale 1ns / 1ps
module vptw_fifo (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           push,
	input  vptw_pkg::clip_t                push_data,
	input  logic                           pop,
	output vptw_pkg::clip_t                head,
	output logic                           empty,
	output logic [vptw_pkg::FIFO_CW-1:0]   count
);
	import vptw_pkg::*;

	clip_t              mem_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wr_ptr_q;
	logic [FIFO_AW-1:0] rd_ptr_q;
	logic [FIFO_CW-1:0] count_q;

	// Storage is written at the tail; the front never pushes into a full queue.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	assign head  = mem_q[rd_ptr_q];
	assign empty = (count_q == '0);
	assign count = count_q;

endmodule

// File: design/vptw_front.sv
// Front: accepts beats, keeps the matrix store and runs both matrix transforms.
`timescale 1ns / 1ps
module vptw_front (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  vptw_pkg::in_beat_t           in_beat,
	input  logic [vptw_pkg::FIFO_CW-1:0] fifo_count,
	output logic                         push,
	output vptw_pkg::clip_t              push_data
);
	import vptw_pkg::*;

	localparam int PEND_W = FIFO_CW + 1;

	fx_t                     mat_q [MAT_DEPTH];
	logic signed [PROD_W-1:0] prod_s1 [4][4];
	logic signed [PROD_W-1:0] prod_s3 [4][4];
	fx_t                     eye_s2 [4];
	fx_t                     clip_s4 [4];
	logic                    v_s1, v_s2, v_s3, v_s4;
	logic [PEND_W-1:0]       pending;
	logic                    accept;

	// Floor shift by the fraction bits, then saturate to a coordinate.
	function automatic fx_t acc_to_fx(input logic signed [ACC_W-1:0] acc);
		logic signed [ACC_W-1:0] sh;
		sh = acc >>> FB;
		if (sh > ACC_W'(FX_MAX)) begin
			return FX_MAX;
		end else if (sh < ACC_W'(FX_MIN)) begin
			return FX_MIN;
		end
		return fx_t'(sh[COORD_W-1:0]);
	endfunction

	// Points in flight plus queued points must fit in the queue. A load waits
	// while a point still has to read the projection matrix.
	assign pending = {1'b0, fifo_count} + PEND_W'(v_s1) + PEND_W'(v_s2)
		+ PEND_W'(v_s3) + PEND_W'(v_s4);

	always_comb begin
		if (in_beat.req_type == REQ_PROJECT) begin
			in_stall = (pending >= PEND_W'(FIFO_DEPTH));
		end else begin
			in_stall = v_s1 || v_s2;
		end
	end

	assign accept = in_valid && !in_stall;

	// Matrix store.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int n = 0; n < MAT_DEPTH; n++) begin
				mat_q[n] <= '0;
			end
		end else if (accept && in_beat.req_type == REQ_LOAD) begin
			mat_q[in_beat.elem_index] <= in_beat.elem_value;
		end
	end

	// Stage valids; the front pipeline never stalls.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= accept && (in_beat.req_type == REQ_PROJECT);
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// Stage 1: object point times model matrix, w taken as exactly one.
	always_ff @(posedge clk) begin
		for (int i = 0; i < 4; i++) begin
			prod_s1[i][0] <= in_beat.obj_x * mat_q[MAT_AW'(i)];
			prod_s1[i][1] <= in_beat.obj_y * mat_q[MAT_AW'(4 + i)];
			prod_s1[i][2] <= in_beat.obj_z * mat_q[MAT_AW'(8 + i)];
			prod_s1[i][3] <= PROD_W'(mat_q[MAT_AW'(12 + i)]) <<< FB;
		end
	end

	// Stage 2: eye-space point.
	always_ff @(posedge clk) begin
		for (int i = 0; i < 4; i++) begin
			eye_s2[i] <= acc_to_fx(ACC_W'(prod_s1[i][0]) + ACC_W'(prod_s1[i][1])
				+ ACC_W'(prod_s1[i][2]) + ACC_W'(prod_s1[i][3]));
		end
	end

	// Stage 3: eye point times projection matrix.
	always_ff @(posedge clk) begin
		for (int i = 0; i < 4; i++) begin
			for (int k = 0; k < 4; k++) begin
				prod_s3[i][k] <= eye_s2[k] * mat_q[MAT_AW'(PROJ_BASE + 4 * k + i)];
			end
		end
	end

	// Stage 4: clip-space point.
	always_ff @(posedge clk) begin
		for (int i = 0; i < 4; i++) begin
			clip_s4[i] <= acc_to_fx(ACC_W'(prod_s3[i][0]) + ACC_W'(prod_s3[i][1])
				+ ACC_W'(prod_s3[i][2]) + ACC_W'(prod_s3[i][3]));
		end
	end

	assign push           = v_s4;
	assign push_data.x    = clip_s4[0];
	assign push_data.y    = clip_s4[1];
	assign push_data.z    = clip_s4[2];
	assign push_data.w    = clip_s4[3];

endmodule

// File: design/vptw_back.sv
// Back: perspective divide, range map and viewport map with the output register.
`timescale 1ns / 1ps
module vptw_back (
	input  logic                clk,
	input  logic                arst_n,
	input  vptw_pkg::vp_cfg_t   cfg,
	input  vptw_pkg::clip_t     head,
	input  logic                empty,
	output logic                pop,
	output logic                out_valid,
	input  logic                out_stall,
	output vptw_pkg::out_beat_t out_beat
);
	import vptw_pkg::*;

	localparam int NST   = COORD_W;       // one quotient bit per stage
	localparam int NUM_W = COORD_W + FB;  // numerator clip * 2^FB
	localparam int VP_W  = COORD_W + 17;  // unit * size + origin

	logic               en;
	logic               v_s   [NST+1];
	logic [COORD_W-1:0] d_s   [NST+1];
	logic               zero_s[NST+1];
	logic [2:0]         neg_s [NST+1];
	logic [2:0]         ovf_s [NST+1];
	logic [COORD_W-1:0] rem_s [NST+1][3];
	logic [COORD_W-1:0] nq_s  [NST+1][3];
	logic [COORD_W-1:0] rem_nx[NST][3];
	logic [COORD_W-1:0] nq_nx [NST][3];

	fx_t                lane_in [3];
	logic [COORD_W-1:0] d_in;
	logic [NUM_W-1:0]   mag_in [3];
	logic [2:0]         neg_in;
	logic [2:0]         ovf_in;

	fx_t                unit_nx [3];
	fx_t                unit_su [3];
	logic               zero_su;
	logic               v_su;

	logic signed [VP_W-1:0] vx, vy;
	out_beat_t          out_q;
	logic               v_out_q;

	function automatic fx_t sat_vp(input logic signed [VP_W-1:0] v);
		if (v > VP_W'(FX_MAX)) begin
			return FX_MAX;
		end else if (v < VP_W'(FX_MIN)) begin
			return FX_MIN;
		end
		return fx_t'(v[COORD_W-1:0]);
	endfunction

	// The whole back pipeline moves unless a finished beat waits.
	assign en  = !v_out_q || !out_stall;
	assign pop = en && !empty;

	// Divider setup: magnitudes, quotient sign and early overflow.
	assign lane_in[0] = head.x;
	assign lane_in[1] = head.y;
	assign lane_in[2] = head.z;
	assign d_in = head.w[COORD_W-1] ? COORD_W'(-head.w) : COORD_W'(head.w);

	always_comb begin
		logic signed [NUM_W-1:0] num;
		for (int l = 0; l < 3; l++) begin
			num       = NUM_W'(lane_in[l]) <<< FB;
			mag_in[l] = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
			neg_in[l] = lane_in[l][COORD_W-1] ^ head.w[COORD_W-1];
			ovf_in[l] = {{(COORD_W-FB){1'b0}}, mag_in[l][NUM_W-1:COORD_W]} >= d_in;
		end
	end

	// One restoring step per stage for each lane.
	always_comb begin
		logic [COORD_W:0] t;
		logic [COORD_W:0] diff;
		logic             ge;
		for (int j = 0; j < NST; j++) begin
			for (int l = 0; l < 3; l++) begin
				t            = {rem_s[j][l], nq_s[j][l][COORD_W-1]};
				diff         = t - {1'b0, d_s[j]};
				ge           = (t >= {1'b0, d_s[j]});
				rem_nx[j][l] = ge ? diff[COORD_W-1:0] : t[COORD_W-1:0];
				nq_nx[j][l]  = {nq_s[j][l][COORD_W-2:0], ge};
			end
		end
	end

	// Divider stage valids.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j <= NST; j++) begin
				v_s[j] <= 1'b0;
			end
		end else if (en) begin
			v_s[0] <= pop;
			for (int j = 0; j < NST; j++) begin
				v_s[j+1] <= v_s[j];
			end
		end
	end

	// Divider stage data.
	always_ff @(posedge clk) begin
		if (en) begin
			d_s[0]    <= d_in;
			zero_s[0] <= (head.w == '0);
			neg_s[0]  <= neg_in;
			ovf_s[0]  <= ovf_in;
			for (int l = 0; l < 3; l++) begin
				rem_s[0][l] <= {{(COORD_W-FB){1'b0}}, mag_in[l][NUM_W-1:COORD_W]};
				nq_s[0][l]  <= mag_in[l][COORD_W-1:0];
			end
			for (int j = 0; j < NST; j++) begin
				d_s[j+1]    <= d_s[j];
				zero_s[j+1] <= zero_s[j];
				neg_s[j+1]  <= neg_s[j];
				ovf_s[j+1]  <= ovf_s[j];
				for (int l = 0; l < 3; l++) begin
					rem_s[j+1][l] <= rem_nx[j][l];
					nq_s[j+1][l]  <= nq_nx[j][l];
				end
			end
		end
	end

	// Signed, saturated quotient, then (ndc + 1) / 2 rounded down.
	always_comb begin
		logic [COORD_W-1:0]    qm;
		fx_t                   ndc;
		logic signed [COORD_W:0] t;
		for (int l = 0; l < 3; l++) begin
			qm = nq_s[NST][l];
			if (ovf_s[NST][l]) begin
				ndc = neg_s[NST][l] ? FX_MIN : FX_MAX;
			end else if (neg_s[NST][l]) begin
				ndc = (qm > COORD_W'(FX_MIN)) ? FX_MIN : fx_t'(-qm);
			end else begin
				ndc = qm[COORD_W-1] ? FX_MAX : fx_t'(qm);
			end
			t          = (COORD_W+1)'(ndc) + (COORD_W+1)'(ONE_FX);
			unit_nx[l] = fx_t'(t[COORD_W:1]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_su <= 1'b0;
		end else if (en) begin
			v_su <= v_s[NST];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			unit_su <= unit_nx;
			zero_su <= zero_s[NST];
		end
	end

	// Viewport map.
	assign vx = unit_su[0] * $signed({1'b0, cfg.width}) + (VP_W'(cfg.origin_x) <<< FB);
	assign vy = unit_su[1] * $signed({1'b0, cfg.height}) + (VP_W'(cfg.origin_y) <<< FB);

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_out_q <= 1'b0;
		end else if (en) begin
			v_out_q <= v_su;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (zero_su) begin
				out_q <= '0;
			end else begin
				out_q.win_x <= sat_vp(vx);
				out_q.win_y <= sat_vp(vy);
				out_q.win_z <= unit_su[2];
				out_q.ok    <= 1'b1;
			end
		end
	end

	assign out_valid = v_out_q;
	assign out_beat  = out_q;

endmodule

// File: design/vertex_project_to_window_unit.sv
// Top level: configuration registers, transform front, queue and divide back.
// A load beat writes the matrix store at its accepting edge and gives no result.
// A project beat passes four transform stages, the queue, a divider setup register,
// 32 divide stages and two map stages, the last of which is the output register.
// One beat is taken per cycle while in_stall is low; a load waits while a point is in the first two transform stages.
// Reset clears the matrix store, the viewport registers, the queue and all valids.
`timescale 1ns / 1ps
module vertex_project_to_window_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  vptw_pkg::in_beat_t              in_beat,
	output logic                            out_valid,
	input  logic                            out_stall,
	output vptw_pkg::out_beat_t             out_beat,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [vptw_pkg::APB_AW-1:0]     paddr,
	input  logic [vptw_pkg::APB_DW-1:0]     pwdata,
	output logic [vptw_pkg::APB_DW-1:0]     prdata,
	output logic                            pready
);
	import vptw_pkg::*;

	vp_cfg_t            cfg_q;
	logic               cfg_wr;
	logic               push;
	clip_t              push_data;
	logic               pop;
	clip_t              head;
	logic               empty;
	logic [FIFO_CW-1:0] count;

	// Register writes.
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				REG_VP_ORIGIN_X: cfg_q.origin_x <= pwdata[15:0];
				REG_VP_ORIGIN_Y: cfg_q.origin_y <= pwdata[15:0];
				REG_VP_WIDTH:    cfg_q.width    <= pwdata[14:0];
				REG_VP_HEIGHT:   cfg_q.height   <= pwdata[14:0];
				default: ;
			endcase
		end
	end

	// Register reads.
	always_comb begin
		case (paddr[3:2])
			REG_VP_ORIGIN_X: prdata = APB_DW'(cfg_q.origin_x);
			REG_VP_ORIGIN_Y: prdata = APB_DW'(cfg_q.origin_y);
			REG_VP_WIDTH:    prdata = {17'b0, cfg_q.width};
			REG_VP_HEIGHT:   prdata = {17'b0, cfg_q.height};
			default:         prdata = '0;
		endcase
	end

	vptw_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.in_beat    (in_beat),
		.fifo_count (count),
		.push       (push),
		.push_data  (push_data)
	);

	vptw_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.head      (head),
		.empty     (empty),
		.count     (count)
	);

	vptw_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.head      (head),
		.empty     (empty),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_beat  (out_beat)
	);

endmodule

// File: design/vptw_checker.sv
// Port-level checks for the vertex projection unit, bound to the top level.
`timescale 1ns / 1ps
module vptw_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                out_valid,
	input logic                out_stall,
	input vptw_pkg::out_beat_t out_beat
);
	import vptw_pkg::*;

	// A stalled result beat stays put.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_beat))
		else $error("result beat changed while stalled");

	// A failed projection reports zero coordinates.
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_beat.ok |->
			out_beat.win_x == '0 && out_beat.win_y == '0 && out_beat.win_z == '0)
		else $error("failed projection with nonzero coordinates");

	// No result can appear right after reset is released.
	a_reset_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(arst_n) |-> !out_valid)
		else $error("result beat right after reset");

endmodule

bind vertex_project_to_window_unit vptw_checker u_vptw_checker (.*);
